// File: rtl/ucs_pkg.sv
// ucs_pkg: shared types and constants of the used channel stepper
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package ucs_pkg;

    // channel numbers run 1 .. CHANNEL_COUNT, carried in CH_W bits
    localparam int CHANNEL_COUNT = 16;
    localparam int CH_W          = 5;
    localparam int IDX_W         = $clog2(CHANNEL_COUNT);
    localparam int FREQ_W        = 32;
    localparam int TONE_W        = 6;
    localparam int STEP_W        = 8;
    localparam int KIND_W        = 2;

    localparam logic [CH_W-1:0] CH_FIRST = CH_W'(1);
    localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNEL_COUNT);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOME = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [CH_W-1:0]          entry_slot;
        logic                     entry_in_use;
        logic [FREQ_W-1:0]        entry_receive;
        logic [FREQ_W-1:0]        entry_transmit;
        logic                     entry_tone_enabled;
        logic [TONE_W-1:0]        entry_tone_number;
        logic signed [STEP_W-1:0] step_count;
        logic                     reverse_pressed;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]   shown_channel;
        logic [FREQ_W-1:0] receive_frequency;
        logic [FREQ_W-1:0] transmit_frequency;
        logic              tone_enabled;
        logic [TONE_W-1:0] tone_number;
        logic              no_channel_available;
    } result_t;

    // stored part of a channel record (used flag kept apart)
    typedef struct packed {
        logic [FREQ_W-1:0] receive;
        logic [FREQ_W-1:0] transmit;
        logic              tone_enabled;
        logic [TONE_W-1:0] tone_number;
    } record_t;

    typedef struct packed {
        logic capture;   // latch the accepted beat, write a load, set up the walk
        logic advance;   // move one channel position
        logic emit;      // fill the output register
    } ctl_cmd_t;

    typedef struct packed {
        logic walk_done;
    } dp_status_t;

endpackage

// File: rtl/ucs_ctrl.sv
// ucs_ctrl: controller state machine of the used channel stepper
// depends on ucs_pkg; drives ucs_datapath through ctl_cmd_t
`timescale 1ns / 1ps

module ucs_ctrl import ucs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.walk_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/ucs_datapath.sv
// ucs_datapath: channel table, current channel, walk counter and output register
// depends on ucs_pkg; commanded by ucs_ctrl
`timescale 1ns / 1ps

module ucs_datapath import ucs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  item_t      item,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    output result_t    result
);

    // control state
    logic                    write_mode_reg;
    logic [CH_W-1:0]         cur_reg, cur_next;
    logic [STEP_W-1:0]       left_reg, left_next;
    logic                    up_reg, up_next;
    logic                    count_all_reg, count_all_next;
    logic                    none_reg, none_next;
    logic [CHANNEL_COUNT-1:0] used_reg, used_next;
    logic [CHANNEL_COUNT-1:0] written_reg, written_next;

    // payload
    record_t                 rec_mem [CHANNEL_COUNT];
    logic                    reverse_reg;
    result_t                 result_reg;

    logic                    slot_ok;
    logic [IDX_W-1:0]        wr_idx;
    logic                    any_used;
    logic                    step_up;
    logic [STEP_W-1:0]       step_raw;
    logic [STEP_W-1:0]       step_mag;
    logic [CH_W-1:0]         cur_step;
    logic [CH_W-1:0]         cur_step_m1;
    logic [CH_W-1:0]         cur_m1;
    logic                    hit;
    logic [IDX_W-1:0]        rd_idx;
    record_t                 rd_rec;
    logic                    rd_used;
    logic                    is_load;

    assign slot_ok  = (item.entry_slot >= CH_FIRST) && (item.entry_slot <= CH_LAST);
    assign wr_idx   = item.entry_slot[IDX_W-1:0] - IDX_W'(1);
    assign any_used = |used_reg;
    assign is_load  = cmd.capture && (item.kind == KIND_LOAD) && slot_ok;

    assign step_raw = $unsigned(item.step_count);
    assign step_up  = !step_raw[STEP_W-1];
    assign step_mag = step_up ? step_raw : (~step_raw + STEP_W'(1));

    // one position around the ring
    always_comb begin
        if (up_reg) begin
            cur_step = (cur_reg >= CH_LAST) ? CH_FIRST : cur_reg + CH_W'(1);
        end else begin
            cur_step = (cur_reg <= CH_FIRST) ? CH_LAST : cur_reg - CH_W'(1);
        end
    end
    assign cur_step_m1 = cur_step - CH_W'(1);
    assign hit         = count_all_reg || used_reg[cur_step_m1[IDX_W-1:0]];

    assign status.walk_done = (left_reg == '0);

    always_comb begin
        cur_next       = cur_reg;
        left_next      = left_reg;
        up_next        = up_reg;
        count_all_next = count_all_reg;
        none_next      = none_reg;
        used_next      = used_reg;
        written_next   = written_reg;
        if (cmd.capture) begin
            none_next = 1'b0;
            left_next = '0;
            case (item.kind)
                KIND_LOAD: begin
                    if (slot_ok) begin
                        used_next[wr_idx]    = item.entry_in_use;
                        written_next[wr_idx] = 1'b1;
                    end
                end
                KIND_STEP: begin
                    up_next        = step_up;
                    count_all_next = write_mode_reg;
                    if (!write_mode_reg && !any_used) begin
                        none_next = (step_mag != '0);
                    end else begin
                        left_next = step_mag;
                    end
                end
                KIND_HOME: begin
                    // walk up one used channel from the top: lands on the lowest used
                    cur_next       = CH_LAST;
                    up_next        = 1'b1;
                    count_all_next = 1'b0;
                    left_next      = any_used ? STEP_W'(1) : '0;
                end
                default: begin
                    left_next = '0;
                end
            endcase
        end else if (cmd.advance) begin
            cur_next = cur_step;
            if (hit) begin
                left_next = left_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_mode_reg <= 1'b0;
            cur_reg        <= CH_LAST;
            left_reg       <= '0;
            up_reg         <= 1'b1;
            count_all_reg  <= 1'b0;
            none_reg       <= 1'b0;
            used_reg       <= '0;
            written_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                write_mode_reg <= cfg_wr_data;
            end
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            up_reg        <= up_next;
            count_all_reg <= count_all_next;
            none_reg      <= none_next;
            used_reg      <= used_next;
            written_reg   <= written_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_load) begin
            rec_mem[wr_idx] <= '{receive:      item.entry_receive,
                                 transmit:     item.entry_transmit,
                                 tone_enabled: item.entry_tone_enabled,
                                 tone_number:  item.entry_tone_number};
        end
        if (cmd.capture) begin
            reverse_reg <= item.reverse_pressed;
        end
    end

    // record read at the current channel; never-loaded entries read as zero
    assign cur_m1  = cur_reg - CH_W'(1);
    assign rd_idx  = cur_m1[IDX_W-1:0];
    assign rd_rec  = written_reg[rd_idx] ? rec_mem[rd_idx] : '0;
    assign rd_used = used_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            result_reg.shown_channel <= cur_reg;
            if (rd_used) begin
                result_reg.receive_frequency  <= reverse_reg ? rd_rec.transmit : rd_rec.receive;
                result_reg.transmit_frequency <= reverse_reg ? rd_rec.receive : rd_rec.transmit;
            end else begin
                result_reg.receive_frequency  <= '0;
                result_reg.transmit_frequency <= '0;
            end
            result_reg.tone_enabled         <= rd_rec.tone_enabled;
            result_reg.tone_number          <= rd_rec.tone_number;
            result_reg.no_channel_available <= none_reg;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/used_channel_stepper_core.sv
// used_channel_stepper_core: top level of the used channel stepper
// depends on ucs_pkg, ucs_ctrl and ucs_datapath
`timescale 1ns / 1ps

// usage
//   s_ channel: one beat per command. s_tuser carries the kind (load, step, home),
//   s_tdata the record for a load, the signed step count and the reverse flag.
//   m_ channel: one beat per command with the current channel, its frequencies
//   (swapped when reverse is set, zero for an unused channel), tone fields and
//   the no-channel flag. cfg_wr_en / cfg_wr_data set write mode; write only
//   while no command is in flight.
// walk
//   a result is emitted once the walk around the ring is done. load and
//   home-with-nothing-used walk nothing; a step walks up to |count| x 16
//   positions, home up to 16. the walk is a single shared increment/decrement
//   unit stepping the current channel once per cycle, so items are handled
//   one at a time.
// reset
//   aresetn low clears the table to unused and zero, current channel to 16,
//   write mode off, and the output valid flag; the controller returns to idle.
// backpressure
//   the result sits in an output register until m_tready; the next input beat
//   is taken meanwhile and its result waits in the datapath for the slot.
module used_channel_stepper_core import ucs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // write_mode
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] entry_slot, [5] entry_in_use, [37:6] entry_receive,
    // [69:38] entry_transmit, [70] entry_tone_enabled, [76:71] entry_tone_number,
    // [84:77] step_count, [85] reverse_pressed, [87:86] zero
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,        // [1:0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] shown_channel, [36:5] receive_frequency, [68:37] transmit_frequency,
    // [69] tone_enabled, [75:70] tone_number, [76] no_channel_available,
    // [79:77] zero
    output logic [79:0] m_tdata
);

    item_t      item;
    result_t    result;
    ctl_cmd_t   cmd;
    dp_status_t status;

    // unpack the input beat
    assign item.kind               = s_tuser;
    assign item.entry_slot         = s_tdata[4:0];
    assign item.entry_in_use       = s_tdata[5];
    assign item.entry_receive      = s_tdata[37:6];
    assign item.entry_transmit     = s_tdata[69:38];
    assign item.entry_tone_enabled = s_tdata[70];
    assign item.entry_tone_number  = s_tdata[76:71];
    assign item.step_count         = $signed(s_tdata[84:77]);
    assign item.reverse_pressed    = s_tdata[85];

    // sequencing: idle, walk the ring, hand over to the output register
    ucs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // channel table, current channel and result register
    ucs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

    // pack the result beat
    assign m_tdata = {3'b000,
                      result.no_channel_available,
                      result.tone_number,
                      result.tone_enabled,
                      result.transmit_frequency,
                      result.receive_frequency,
                      result.shown_channel};

endmodule

// File: test/used_channel_stepper_core_tb.sv
// used_channel_stepper_core_tb: self-checking testbench of the used channel stepper
// drives command beats, checks every result beat against its own channel table or a hand-written result
// depends on ucs_pkg and used_channel_stepper_core
`timescale 1ns / 1ps

module used_channel_stepper_core_tb;
    import ucs_pkg::*;

    // kind code the block does not know; it must only report the current channel
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int PHASE_COUNT      = 8;
    localparam int RANDOM_PER_PHASE = 188;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 16;

    // idle percentages of the four traffic modes: none, sender, receiver, both
    localparam int TX_IDLE [4] = '{0, 80, 0, 7};
    localparam int RX_IDLE [4] = '{0, 0, 80, 7};

    typedef struct {
        logic    mode;      // write mode in force for this row
        item_t   cmd;
        bit      typed;     // want holds a hand-written result
        result_t want;
    } script_row_t;

    // dut ports, the driven ones known from time zero
    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [79:0] m_tdata;

    // predicted block state
    logic [CHANNEL_COUNT:1] chan_used;
    record_t                chan_rec [1:CHANNEL_COUNT];
    logic [CH_W-1:0]        cur_channel;
    logic                   write_mode_now;

    result_t     pending_views [$];
    script_row_t script [$];

    // traffic shaping, set per phase
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit hold_off_req  = 1'b0;

    // run statistics
    int cycles          = 0;
    int mismatches      = 0;
    int results_checked = 0;
    int loads_sent      = 0;
    int steps_sent      = 0;
    int homes_sent      = 0;
    int others_sent     = 0;
    int empty_flags     = 0;
    int config_writes   = 0;

    used_channel_stepper_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor: applies one command to the table and returns the view
    // ------------------------------------------------------------------
    task automatic apply_command(input item_t it, output result_t view);
        int left;
        int c;
        bit up;
        bit none;
        none = 1'b0;
        case (it.kind)
            KIND_LOAD: begin
                // slot 0 and slots past the table are dropped
                if (it.entry_slot >= CH_FIRST && it.entry_slot <= CH_LAST) begin
                    chan_used[it.entry_slot]             = it.entry_in_use;
                    chan_rec[it.entry_slot].receive      = it.entry_receive;
                    chan_rec[it.entry_slot].transmit     = it.entry_transmit;
                    chan_rec[it.entry_slot].tone_enabled = it.entry_tone_enabled;
                    chan_rec[it.entry_slot].tone_number  = it.entry_tone_number;
                end
            end
            KIND_STEP: begin
                left = $signed(it.step_count);
                up   = (left >= 0);
                if (!up)
                    left = -left;
                if (left != 0 && !write_mode_now && chan_used == '0) begin
                    // nothing to land on: stay put and flag it
                    none = 1'b1;
                end else begin
                    // walk the ring; only counted channels use up the step
                    while (left != 0) begin
                        if (up)
                            cur_channel = (cur_channel >= CH_LAST) ? CH_FIRST
                                                                   : cur_channel + 1'b1;
                        else
                            cur_channel = (cur_channel <= CH_FIRST) ? CH_LAST
                                                                    : cur_channel - 1'b1;
                        if (write_mode_now || chan_used[cur_channel])
                            left--;
                    end
                end
            end
            KIND_HOME: begin
                // lowest used channel, last channel when none is used
                cur_channel = CH_LAST;
                for (c = CHANNEL_COUNT; c >= 1; c--)
                    if (chan_used[c])
                        cur_channel = CH_W'(c);
            end
            default: ;
        endcase

        view.shown_channel = cur_channel;
        if (chan_used[cur_channel]) begin
            view.receive_frequency  = it.reverse_pressed ? chan_rec[cur_channel].transmit
                                                         : chan_rec[cur_channel].receive;
            view.transmit_frequency = it.reverse_pressed ? chan_rec[cur_channel].receive
                                                         : chan_rec[cur_channel].transmit;
        end else begin
            view.receive_frequency  = '0;
            view.transmit_frequency = '0;
        end
        view.tone_enabled         = chan_rec[cur_channel].tone_enabled;
        view.tone_number          = chan_rec[cur_channel].tone_number;
        view.no_channel_available = none;
    endtask

    // ------------------------------------------------------------------
    // command builders
    // ------------------------------------------------------------------
    function automatic item_t load_cmd(input logic [CH_W-1:0] slot, input logic in_use,
                                       input logic [FREQ_W-1:0] rx,
                                       input logic [FREQ_W-1:0] tx,
                                       input logic ten, input logic [TONE_W-1:0] tnum);
        item_t it;
        it                    = '0;
        it.kind               = KIND_LOAD;
        it.entry_slot         = slot;
        it.entry_in_use       = in_use;
        it.entry_receive      = rx;
        it.entry_transmit     = tx;
        it.entry_tone_enabled = ten;
        it.entry_tone_number  = tnum;
        return it;
    endfunction

    function automatic item_t plain_cmd(input logic [KIND_W-1:0] kind,
                                        input logic [STEP_W-1:0] cnt, input logic rev);
        item_t it;
        it                 = '0;
        it.kind            = kind;
        it.step_count      = cnt;
        it.reverse_pressed = rev;
        return it;
    endfunction

    function automatic result_t show(input logic [CH_W-1:0] ch,
                                     input logic [FREQ_W-1:0] rx,
                                     input logic [FREQ_W-1:0] tx,
                                     input logic ten, input logic [TONE_W-1:0] tnum,
                                     input logic none);
        result_t r;
        r.shown_channel        = ch;
        r.receive_frequency    = rx;
        r.transmit_frequency   = tx;
        r.tone_enabled         = ten;
        r.tone_number          = tnum;
        r.no_channel_available = none;
        return r;
    endfunction

    function automatic void add_row(input logic mode, input item_t cmd,
                                    input bit typed, input result_t want);
        script_row_t row;
        row.mode  = mode;
        row.cmd   = cmd;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    // random command: mostly small steps and in-range loads of used channels,
    // with every field filled so all bits toggle even where ignored
    function automatic item_t random_command();
        item_t it;
        int    pick;
        int    mag;
        it.kind               = KIND_LOAD;
        it.entry_slot         = CH_W'($urandom_range(1, CHANNEL_COUNT));
        it.entry_in_use       = ($urandom_range(99) < 75);
        it.entry_receive      = $urandom();
        it.entry_transmit     = $urandom();
        it.entry_tone_enabled = 1'($urandom_range(1));
        it.entry_tone_number  = TONE_W'($urandom_range(63));
        it.step_count         = STEP_W'($urandom_range(255));
        it.reverse_pressed    = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 35) begin
            // slots 17..32 wrap to 17..31 and 0, all outside the table
            if ($urandom_range(9) == 0)
                it.entry_slot = CH_W'($urandom_range(CHANNEL_COUNT + 1, CHANNEL_COUNT + 16));
        end else if (pick < 75) begin
            it.kind = KIND_STEP;
            pick = $urandom_range(99);
            if (pick < 95) begin
                mag = (pick < 80) ? $urandom_range(8) : $urandom_range(32);
                it.step_count = $urandom_range(1) ? STEP_W'(-mag) : STEP_W'(mag);
            end
        end else if (pick < 92) begin
            it.kind = KIND_HOME;
        end else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // config write only with nothing in flight; every command gives a result,
    // so an empty store of expected views means the block is idle
    task automatic set_write_mode(input logic mode);
        s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        write_mode_now  = mode;
        config_writes++;
    endtask

    // offers one beat and returns at the edge that accepts it, tvalid still high
    task automatic send_command(input item_t it, input bit typed, input result_t want);
        result_t view;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        // [4:0] slot, [5] in_use, [37:6] rx, [69:38] tx, [70] tone flag,
        // [76:71] tone number, [84:77] step count, [85] reverse
        s_tdata  <= {2'b00, it.reverse_pressed, it.step_count, it.entry_tone_number,
                     it.entry_tone_enabled, it.entry_transmit, it.entry_receive,
                     it.entry_in_use, it.entry_slot};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);

        apply_command(it, view);
        pending_views.push_back(typed ? want : view);
        case (it.kind)
            KIND_LOAD: loads_sent++;
            KIND_STEP: steps_sent++;
            KIND_HOME: homes_sent++;
            default:   others_sent++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (m_tdata[76])
                empty_flags++;
            if (pending_views.size() == 0) begin
                $error("result beat with nothing expected, channel %0d", m_tdata[4:0]);
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                compare_field("shown_channel", want.shown_channel, m_tdata[4:0]);
                compare_field("receive_frequency", want.receive_frequency, m_tdata[36:5]);
                compare_field("transmit_frequency", want.transmit_frequency, m_tdata[68:37]);
                compare_field("tone_enabled", want.tone_enabled, m_tdata[69]);
                compare_field("tone_number", want.tone_number, m_tdata[75:70]);
                compare_field("no_channel_available", want.no_channel_available,
                              m_tdata[76]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int      i;
        int      p;
        int      s;
        item_t   it;
        result_t none_view;

        // predictor matches the block right after reset
        chan_used      = '0;
        cur_channel    = CH_LAST;
        write_mode_now = 1'b0;
        for (i = 1; i <= CHANNEL_COUNT; i++)
            chan_rec[i] = '0;
        none_view = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; hand-written results only where obvious
        // empty table, write mode off: step flags, zero step and home stay on 16
        add_row(1'b0, plain_cmd(KIND_STEP, 8'h01, 1'b0), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b1));
        add_row(1'b0, plain_cmd(KIND_STEP, 8'h00, 1'b0), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));
        add_row(1'b0, plain_cmd(KIND_HOME, 8'h00, 1'b0), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));
        add_row(1'b0, plain_cmd(KIND_UNUSED, 8'hff, 1'b1), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));
        // loads outside the table change nothing
        add_row(1'b0, load_cmd(5'd0, 1'b1, '1, '1, 1'b1, '1), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));
        add_row(1'b0, load_cmd(5'd17, 1'b1, '1, '1, 1'b1, '1), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));
        add_row(1'b0, load_cmd(5'd31, 1'b1, '1, '1, 1'b1, '1), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));
        // extremes in the last and first slot, reverse swaps the report
        add_row(1'b0, load_cmd(CH_LAST, 1'b1, '1, '0, 1'b1, '1), 1'b1,
                show(CH_LAST, '1, '0, 1'b1, '1, 1'b0));
        add_row(1'b0, plain_cmd(KIND_UNUSED, 8'h00, 1'b1), 1'b1,
                show(CH_LAST, '0, '1, 1'b1, '1, 1'b0));
        add_row(1'b0, load_cmd(CH_FIRST, 1'b1, '0, '1, 1'b0, '0), 1'b1,
                show(CH_LAST, '1, '0, 1'b1, '1, 1'b0));
        // wraparound both ways
        add_row(1'b0, plain_cmd(KIND_STEP, 8'h01, 1'b0), 1'b1,
                show(CH_FIRST, '0, '1, 1'b0, '0, 1'b0));
        add_row(1'b0, plain_cmd(KIND_STEP, 8'hff, 1'b0), 1'b1,
                show(CH_LAST, '1, '0, 1'b1, '1, 1'b0));
        // largest counts each way, then loads of an unused and a used channel
        add_row(1'b0, plain_cmd(KIND_STEP, 8'h7f, 1'b0), 1'b0, none_view);
        add_row(1'b0, plain_cmd(KIND_STEP, 8'h80, 1'b1), 1'b0, none_view);
        add_row(1'b0, load_cmd(5'd5, 1'b0, 32'h1357_9bdf, 32'h2468_ace0, 1'b1, 6'd42),
                1'b0, none_view);
        add_row(1'b0, load_cmd(5'd9, 1'b1, 32'h0bad_f00d, 32'h7fff_ffff, 1'b0, 6'd1),
                1'b0, none_view);
        add_row(1'b0, plain_cmd(KIND_HOME, 8'h00, 1'b1), 1'b0, none_view);
        // write mode on: steps land on unused channels too
        add_row(1'b1, plain_cmd(KIND_STEP, 8'h04, 1'b0), 1'b0, none_view);
        add_row(1'b1, plain_cmd(KIND_STEP, 8'h80, 1'b0), 1'b0, none_view);
        add_row(1'b1, plain_cmd(KIND_HOME, 8'h00, 1'b0), 1'b0, none_view);
        add_row(1'b1, plain_cmd(KIND_STEP, 8'h03, 1'b1), 1'b0, none_view);
        // back off, empty the table again
        add_row(1'b0, load_cmd(CH_FIRST, 1'b0, '0, '0, 1'b0, '0), 1'b0, none_view);
        add_row(1'b0, load_cmd(5'd9, 1'b0, '0, '0, 1'b0, '0), 1'b0, none_view);
        add_row(1'b0, load_cmd(CH_LAST, 1'b0, '0, '0, 1'b0, '0), 1'b0, none_view);
        add_row(1'b0, plain_cmd(KIND_HOME, 8'h00, 1'b0), 1'b1,
                show(CH_LAST, '0, '0, 1'b0, '0, 1'b0));

        foreach (script[i]) begin
            if (script[i].mode != write_mode_now)
                set_write_mode(script[i].mode);
            send_command(script[i].cmd, script[i].typed, script[i].want);
        end

        // random phases: each traffic mode once with write mode off and once on
        for (p = 0; p < PHASE_COUNT; p++) begin
            set_write_mode(p[0]);
            tx_idle_pct  = TX_IDLE[p / 2];
            rx_stall_pct = RX_IDLE[p / 2];
            // start from an empty table so the no-channel case keeps coming back
            for (s = 1; s <= CHANNEL_COUNT; s++) begin
                it              = random_command();
                it.kind         = KIND_LOAD;
                it.entry_slot   = CH_W'(s);
                it.entry_in_use = 1'b0;
                send_command(it, 1'b0, none_view);
            end
            // long receiver hold-off while beats keep coming: input must stall
            if (p == 0)
                hold_off_req = 1'b1;
            for (i = 0; i < RANDOM_PER_PHASE; i++)
                send_command(random_command(), 1'b0, none_view);
        end

        s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d loads, %0d steps, %0d homes, %0d unknown kinds; %0d results checked",
                 loads_sent, steps_sent, homes_sent, others_sent, results_checked);
        $display("%0d write mode changes, %0d no-channel results, %0d mismatches",
                 config_writes, empty_flags, mismatches);
        if (mismatches == 0 && pending_views.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
